// ===== rtl/core/id_index_table_core_defines.svh =====
// ----------------------------------------------------------------------------
// id_index_table_core_defines: assertion macros for the id/index table
// Shared by every file that carries concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ID_INDEX_TABLE_CORE_DEFINES_SVH
`define ID_INDEX_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IIT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("id_index_table assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("id_index_table assertion failed");

`endif

// ===== rtl/core/iit_pkg.sv =====
// ----------------------------------------------------------------------------
// iit_pkg: shared types and constants for the id/index table
// Operation and status codes, command word, table entry, engine states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iit_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 16;
    localparam int TOTAL_W     = 5;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_DONE = 2'd0,
        STAT_FULL = 2'd1,
        STAT_MISS = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    // Command word handed from the front end to the back end.
    typedef struct packed {
        kind_t            op;
        logic             needs_scan;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } cmd_t;

endpackage

// ===== rtl/core/iit_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// iit_cmd_queue: short command queue between front and back end
// Small register ring; full/valid flags decouple the two sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iit_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  iit_pkg::cmd_t wr_cmd,
    output logic          full,
    output logic          rd_valid,
    input  logic          rd_en,
    output iit_pkg::cmd_t rd_cmd
);

    localparam int QD    = iit_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
    localparam int CNT_W = $clog2(QD + 1);

    iit_pkg::cmd_t q_mem [QD];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full     = (cnt_reg == CNT_W'(QD));
    assign rd_valid = (cnt_reg != '0);
    assign rd_cmd   = q_mem[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QD - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QD - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_mem[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ===== rtl/core/iit_front.sv =====
// ----------------------------------------------------------------------------
// iit_front: request intake and decode
// Decodes the request word into a command and queues it for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iit_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  kind,
    input  logic [iit_pkg::KEY_W-1:0]   object_id,
    input  logic [iit_pkg::VAL_W-1:0]   scene_index,
    output logic                        cmd_valid,
    input  logic                        cmd_pop,
    output iit_pkg::cmd_t               cmd
);

    iit_pkg::cmd_t  dec_cmd;
    iit_pkg::kind_t dec_op;

    assign dec_op = iit_pkg::kind_t'(kind);

    always_comb
    begin
        dec_cmd.op         = dec_op;
        // remove and lookup both walk the table
        dec_cmd.needs_scan = (dec_op == iit_pkg::KIND_REMOVE)
                          || (dec_op == iit_pkg::KIND_LOOKUP);
        dec_cmd.key        = object_id;
        dec_cmd.value      = scene_index;
    end

    iit_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_cmd   (dec_cmd),
        .full     (full),
        .rd_valid (cmd_valid),
        .rd_en    (cmd_pop),
        .rd_cmd   (cmd)
    );

endmodule

// ===== rtl/core/iit_back.sv =====
// ----------------------------------------------------------------------------
// iit_back: table engine and result register
// Holds the packed table in a single-port-read memory, scans it one entry
// per cycle, does swap-remove, and parks the result word for the consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iit_back #(
    parameter int DEPTH = iit_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_pop,
    input  iit_pkg::cmd_t                 cmd,
    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    status,
    output logic                          found,
    output logic [iit_pkg::VAL_W-1:0]     found_index,
    output logic [iit_pkg::TOTAL_W-1:0]   entry_total
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    iit_pkg::entry_t mem [DEPTH];
    iit_pkg::entry_t rd_data_reg;

    iit_pkg::state_t          state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            idx_reg, idx_next;
    iit_pkg::kind_t           op_reg, op_next;
    logic [iit_pkg::KEY_W-1:0] key_reg, key_next;
    logic [iit_pkg::VAL_W-1:0] hit_val_reg, hit_val_next;

    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    iit_pkg::entry_t          wr_data;
    logic                     is_last;
    logic [AW-1:0]            last_addr;

    logic                          res_valid_reg;
    iit_pkg::status_t              res_status_reg, res_status_next;
    logic                          res_found_reg, res_found_next;
    logic [iit_pkg::VAL_W-1:0]     res_index_reg, res_index_next;
    logic [iit_pkg::TOTAL_W-1:0]   res_total_reg, res_total_next;
    logic                          res_load;

    assign is_last   = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign last_addr = AW'(count_reg - CW'(1));

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        hit_val_next    = hit_val_reg;
        cmd_pop         = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = rd_data_reg;
        res_load        = 1'b0;
        res_status_next = iit_pkg::STAT_DONE;
        res_found_next  = 1'b0;
        res_index_next  = '0;

        unique case (state_reg)
            iit_pkg::S_IDLE:
            begin
                // start only with the result slot free, so the end never stalls
                if (cmd_valid && !res_valid_reg)
                begin
                    cmd_pop  = 1'b1;
                    op_next  = cmd.op;
                    key_next = cmd.key;
                    if (cmd.needs_scan)
                    begin
                        if (count_reg == '0)
                        begin
                            res_load        = 1'b1;
                            res_status_next = iit_pkg::STAT_MISS;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            idx_next   = '0;
                            state_next = iit_pkg::S_SCAN;
                        end
                    end
                    else if (cmd.op == iit_pkg::KIND_ADD)
                    begin
                        res_load = 1'b1;
                        if (count_reg == CW'(DEPTH))
                        begin
                            res_status_next = iit_pkg::STAT_FULL;
                        end
                        else
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = AW'(count_reg);
                            wr_data.key   = cmd.key;
                            wr_data.value = cmd.value;
                            count_next    = count_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        res_load   = 1'b1;
                        count_next = '0;
                    end
                end
            end
            iit_pkg::S_SCAN:
            begin
                // rd_data_reg holds entry idx_reg
                if (rd_data_reg.key == key_reg)
                begin
                    hit_val_next = rd_data_reg.value;
                    if (op_reg == iit_pkg::KIND_LOOKUP || is_last)
                    begin
                        res_load       = 1'b1;
                        res_found_next = 1'b1;
                        res_index_next = rd_data_reg.value;
                        if (op_reg == iit_pkg::KIND_REMOVE)
                        begin
                            count_next = count_reg - CW'(1);
                        end
                        state_next = iit_pkg::S_IDLE;
                    end
                    else
                    begin
                        // fetch the last pair to fill the hole
                        rd_en      = 1'b1;
                        rd_addr    = last_addr;
                        state_next = iit_pkg::S_MOVE;
                    end
                end
                else if (is_last)
                begin
                    res_load        = 1'b1;
                    res_status_next = iit_pkg::STAT_MISS;
                    state_next      = iit_pkg::S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + AW'(1);
                end
            end
            iit_pkg::S_MOVE:
            begin
                wr_en          = 1'b1;
                wr_addr        = idx_reg;
                wr_data        = rd_data_reg;
                count_next     = count_reg - CW'(1);
                res_load       = 1'b1;
                res_found_next = 1'b1;
                res_index_next = hit_val_reg;
                state_next     = iit_pkg::S_IDLE;
            end
            default:
            begin
                state_next = iit_pkg::S_IDLE;
            end
        endcase

        res_total_next = iit_pkg::TOTAL_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iit_pkg::S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        op_reg      <= op_next;
        key_reg     <= key_next;
        hit_val_reg <= hit_val_next;
        if (res_load)
        begin
            res_status_reg <= res_status_next;
            res_found_reg  <= res_found_next;
            res_index_reg  <= res_index_next;
            res_total_reg  <= res_total_next;
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign empty       = !res_valid_reg;
    assign status      = res_status_reg;
    assign found       = res_found_reg;
    assign found_index = res_index_reg;
    assign entry_total = res_total_reg;

endmodule

// ===== rtl/core/id_index_table_core.sv =====
// Add and clear load their result register at the accepting edge; remove
//   and lookup scan from slot 0 until a hit or the last pair (a swapping
//   remove then passes through a move state); an empty table misses without a scan.
// Engine: one word at a time; the next starts the cycle after the result
//   is popped.
// Reset: asynchronous, active low; clears the count, queue and result flag.
// ----------------------------------------------------------------------------
// id_index_table_core: packed id -> scene index table
// Fixed-depth table of (object id, scene index) pairs kept densely packed.
// Add appends, remove swaps the last pair into the hole, lookup returns the
// first match, clear drops every pair. One result word per request word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module id_index_table_core #(
    parameter int DEPTH = iit_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request side
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    kind,
    input  logic [iit_pkg::KEY_W-1:0]     object_id,
    input  logic [iit_pkg::VAL_W-1:0]     scene_index,
    // result side
    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    status,
    output logic                          found,
    output logic [iit_pkg::VAL_W-1:0]     found_index,
    output logic [iit_pkg::TOTAL_W-1:0]   entry_total
);

    // Front end: decodes each request word into a command and parks it in
    // a two-entry queue, so pushes keep landing while the engine scans.
    logic          cmd_valid;
    logic          cmd_pop;
    iit_pkg::cmd_t cmd;

    iit_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .object_id   (object_id),
        .scene_index (scene_index),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .cmd         (cmd)
    );

    // Back end: owns the table memory and the entry count. It only pulls a
    // command when its result register is free, so a finished result can
    // wait for pop while the queue keeps filling.
    iit_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .cmd         (cmd),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .found       (found),
        .found_index (found_index),
        .entry_total (entry_total)
    );

endmodule

// ===== rtl/core/iit_checker.sv =====
// ----------------------------------------------------------------------------
// iit_checker: port-level checks for the id/index table
// Watches the result side of the top level; bound in below.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "id_index_table_core_defines.svh"

module iit_checker #(
    parameter int DEPTH = iit_pkg::DEPTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          empty,
    input logic                          pop,
    input logic [1:0]                    status,
    input logic                          found,
    input logic [iit_pkg::VAL_W-1:0]     found_index,
    input logic [iit_pkg::TOTAL_W-1:0]   entry_total
);

    logic res_shown;

    assign res_shown = !empty;

    // a waiting result word holds until popped
    `IIT_ASSERT_NEXT(a_res_hold, clk, rst_n, res_shown && !pop, !empty && $stable(status) && $stable(found) && $stable(found_index) && $stable(entry_total))

    // a hit always reports success
    `IIT_ASSERT_IMPL(a_found_done, clk, rst_n, res_shown && found, status == iit_pkg::STAT_DONE)

    // no hit means a zero scene index
    `IIT_ASSERT_IMPL(a_miss_zero, clk, rst_n, res_shown && !found, found_index == '0)

    // a dropped add leaves a full table
    `IIT_ASSERT_IMPL(a_full_total, clk, rst_n, res_shown && (status == iit_pkg::STAT_FULL), entry_total == iit_pkg::TOTAL_W'(DEPTH))

endmodule

bind id_index_table_core iit_checker #(.DEPTH(DEPTH)) u_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for id_index_table_core
// Drives add, remove, lookup and clear words through the queue-style request
// port. A local table model predicts each result word, and a checker process
// compares every popped word against the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;

    localparam int DEPTH      = iit_pkg::DEPTH_DEF;
    localparam int KEY_W      = iit_pkg::KEY_W;
    localparam int VAL_W      = iit_pkg::VAL_W;
    localparam int TOTAL_W    = iit_pkg::TOTAL_W;
    localparam int CLK_HALF   = 10;
    localparam int MAX_IDLE   = 13;
    // Worst correct run is roughly 460 words; allow far more.
    localparam int TIMEOUT_NS = 5_000_000;

    // One predicted result word.
    typedef struct {
        iit_pkg::status_t   status;
        logic               found;
        logic [VAL_W-1:0]   found_index;
        logic [TOTAL_W-1:0] entry_total;
    } table_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [1:0]           kind;
    logic [KEY_W-1:0]     object_id;
    logic [VAL_W-1:0]     scene_index;
    logic                 empty;
    logic                 pop;
    logic [1:0]           status;
    logic                 found;
    logic [VAL_W-1:0]     found_index;
    logic [TOTAL_W-1:0]   entry_total;

    // Local copy of the table: only positions below table_count are valid.
    logic [KEY_W-1:0]     table_keys [DEPTH];
    logic [VAL_W-1:0]     table_vals [DEPTH];
    int                   table_count;

    table_result_t        pending_results[$];
    logic [KEY_W-1:0]     key_pool [6];
    int unsigned          fail_count;
    // When clear, that side runs back to back with no idle cycles.
    bit                   send_idle;
    bit                   recv_idle;

    id_index_table_core #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .kind(kind),
        .object_id(object_id),
        .scene_index(scene_index),
        .empty(empty),
        .pop(pop),
        .status(status),
        .found(found),
        .found_index(found_index),
        .entry_total(entry_total)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("testbench NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Table model. Add appends without a duplicate check and is dropped when
    // the table is full. Remove and lookup act on the lowest matching slot;
    // remove pulls the last pair into the hole (a no-op move when the hit is
    // the last pair). Clear only zeroes the count.
    // ------------------------------------------------------------------------
    function automatic table_result_t predict_table_op(iit_pkg::kind_t op,
                                                       logic [KEY_W-1:0] key,
                                                       logic [VAL_W-1:0] val);
        table_result_t res;
        int            hit;
        int            i;
        res.status      = iit_pkg::STAT_DONE;
        res.found       = 1'b0;
        res.found_index = '0;
        hit             = -1;
        case (op)
            iit_pkg::KIND_ADD:
            begin
                if (table_count >= DEPTH)
                    res.status = iit_pkg::STAT_FULL;
                else
                begin
                    table_keys[table_count] = key;
                    table_vals[table_count] = val;
                    table_count++;
                end
            end
            iit_pkg::KIND_REMOVE, iit_pkg::KIND_LOOKUP:
            begin
                for (i = 0; i < table_count; i++)
                begin
                    if (hit < 0 && table_keys[i] == key)
                        hit = i;
                end
                if (hit < 0)
                    res.status = iit_pkg::STAT_MISS;
                else
                begin
                    res.found       = 1'b1;
                    res.found_index = table_vals[hit];
                    if (op == iit_pkg::KIND_REMOVE)
                    begin
                        table_keys[hit] = table_keys[table_count - 1];
                        table_vals[hit] = table_vals[table_count - 1];
                        table_count--;
                    end
                end
            end
            default:
                table_count = 0;
        endcase
        res.entry_total = table_count[TOTAL_W-1:0];
        return res;
    endfunction

    // Draw a per-word idle count for one side.
    function automatic int idle_cycles(bit enabled);
        return enabled ? int'($urandom_range(0, MAX_IDLE)) : 0;
    endfunction

    // Key choice: mostly ids already in the table or in a small pool, so that
    // hits and duplicates are common; the rest are fully random.
    function automatic logic [KEY_W-1:0] pick_key(iit_pkg::kind_t op);
        int r;
        r = $urandom_range(0, 99);
        if (op != iit_pkg::KIND_ADD && table_count > 0 && r < 50)
            return table_keys[$urandom_range(0, table_count - 1)];
        if (r < 80)
            return key_pool[$urandom_range(0, 5)];
        return $urandom;
    endfunction

    task automatic refresh_key_pool();
        int i;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (i = 2; i < 6; i++)
            key_pool[i] = $urandom;
    endtask

    // Send one word. push is left high after acceptance; the next call either
    // keeps it high (zero gap) or drops it, so push gets one update per edge.
    task automatic send_word(iit_pkg::kind_t op, logic [KEY_W-1:0] key,
                             logic [VAL_W-1:0] val);
        int gap;
        gap = idle_cycles(send_idle);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        kind        <= op;
        object_id   <= key;
        scene_index <= val;
        do
            @(posedge clk);
        while (full);
        pending_results.push_back(predict_table_op(op, key, val));
    endtask

    // Hold off the request side until every predicted word has been popped.
    task automatic wait_table_drained();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random pop stalls, then compare each popped word with the
    // oldest prediction, field by field.
    // ------------------------------------------------------------------------
    task automatic check_result();
        table_result_t exp_res;
        if (pending_results.size() == 0)
        begin
            $error("unexpected result word: status %0d found %0d found_index %0d entry_total %0d",
                   status, found, found_index, entry_total);
            fail_count++;
            return;
        end
        exp_res = pending_results.pop_front();
        if (status !== exp_res.status)
        begin
            $error("status: expected %0d, actual %0d", exp_res.status, status);
            fail_count++;
        end
        if (found !== exp_res.found)
        begin
            $error("found: expected %0d, actual %0d", exp_res.found, found);
            fail_count++;
        end
        if (found_index !== exp_res.found_index)
        begin
            $error("found_index: expected 0x%04h, actual 0x%04h", exp_res.found_index,
                   found_index);
            fail_count++;
        end
        if (entry_total !== exp_res.entry_total)
        begin
            $error("entry_total: expected %0d, actual %0d", exp_res.entry_total, entry_total);
            fail_count++;
        end
    endtask

    initial
    begin
        int stall;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = idle_cycles(recv_idle);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            check_result();
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Extremes and the named corner cases: misses on an empty table, extreme
    // keys and values, duplicate keys, remove with a swap from the end,
    // remove of the last pair, add to a full table, clear.
    task automatic test_directed_cases();
        int i;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        send_word(iit_pkg::KIND_LOOKUP, '0, '1);
        send_word(iit_pkg::KIND_REMOVE, '1, '0);
        send_word(iit_pkg::KIND_ADD, '0, '1);
        send_word(iit_pkg::KIND_ADD, '1, '0);
        send_word(iit_pkg::KIND_ADD, '0, 16'h1234);
        send_word(iit_pkg::KIND_LOOKUP, '0, '0);
        send_word(iit_pkg::KIND_LOOKUP, '1, '1);
        // first id-0 pair goes, the duplicate at the end moves into slot 0
        send_word(iit_pkg::KIND_REMOVE, '0, '0);
        send_word(iit_pkg::KIND_LOOKUP, '0, '0);
        // all-ones id now sits in the last slot
        send_word(iit_pkg::KIND_REMOVE, '1, '0);
        for (i = 0; i < DEPTH - 1; i++)
            send_word(iit_pkg::KIND_ADD, $urandom, $urandom_range(0, 65535));
        send_word(iit_pkg::KIND_ADD, '1, '1);
        send_word(iit_pkg::KIND_CLEAR, '1, '1);
    endtask

    // Fill past full, churn with removes and lookups, refill, clear; both
    // sides run with no idle cycles.
    task automatic test_full_churn();
        int             i;
        iit_pkg::kind_t op;
        send_idle = 1'b0;
        recv_idle = 1'b0;
        refresh_key_pool();
        send_word(iit_pkg::KIND_CLEAR, $urandom, $urandom_range(0, 65535));
        for (i = 0; i < DEPTH + 2; i++)
            send_word(iit_pkg::KIND_ADD, pick_key(iit_pkg::KIND_ADD),
                      $urandom_range(0, 65535));
        for (i = 0; i < 8; i++)
        begin
            op = i[0] ? iit_pkg::KIND_LOOKUP : iit_pkg::KIND_REMOVE;
            send_word(op, pick_key(op), $urandom_range(0, 65535));
        end
        for (i = 0; i < 3; i++)
            send_word(iit_pkg::KIND_ADD, pick_key(iit_pkg::KIND_ADD),
                      $urandom_range(0, 65535));
        send_word(iit_pkg::KIND_CLEAR, $urandom, $urandom_range(0, 65535));
    endtask

    // Random operation mix. Idling is re-drawn every 50 words; the first
    // block has idling on both sides, the second none. Halfway through the
    // request side waits for the table to drain completely.
    task automatic test_random_mix(int n_words);
        int             i;
        int             r;
        iit_pkg::kind_t op;
        for (i = 0; i < n_words; i++)
        begin
            if (i % 50 == 0)
            begin
                refresh_key_pool();
                if (i == 0)
                begin
                    send_idle = 1'b1;
                    recv_idle = 1'b1;
                end
                else if (i == 50)
                begin
                    send_idle = 1'b0;
                    recv_idle = 1'b0;
                end
                else
                begin
                    send_idle = ($urandom_range(0, 3) != 0);
                    recv_idle = ($urandom_range(0, 3) != 0);
                end
            end
            if (i == n_words / 2)
                wait_table_drained();
            r = $urandom_range(0, 99);
            if (r < 48)
                op = iit_pkg::KIND_ADD;
            else if (r < 70)
                op = iit_pkg::KIND_REMOVE;
            else if (r < 97)
                op = iit_pkg::KIND_LOOKUP;
            else
                op = iit_pkg::KIND_CLEAR;
            send_word(op, pick_key(op), $urandom_range(0, 65535));
        end
    endtask

    initial
    begin
        fail_count  = 0;
        table_count = 0;
        send_idle   = 1'b0;
        recv_idle   = 1'b0;
        rst_n       <= 1'b0;
        push        <= 1'b0;
        kind        <= iit_pkg::KIND_ADD;
        object_id   <= '0;
        scene_index <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_full_churn();
        test_random_mix(400);

        // Drain: wait for every prediction, then a full miss-scan worth of
        // cycles to catch any stray extra word.
        wait_table_drained();
        repeat (DEPTH + 8) @(posedge clk);

        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
